>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of the execute core.
// Depends on nothing; the user supplies aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sce_pkg.sv
// Shared types, constants and helpers of the instruction execute core.
// Depends on nothing; used by the core, its checkers and its test.
package sce_pkg;

    localparam int unsigned REG_COUNT    = 16;
    localparam int unsigned DATA_WORDS   = 4096;
    localparam int unsigned IO_REG_COUNT = 23;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned PC_W      = 12;
    localparam int unsigned REG_IDX_W = 4;
    localparam int unsigned IMM_W     = 12;
    localparam int unsigned IRQ_W     = 3;
    localparam int unsigned SHAMT_W   = 5;
    localparam int unsigned IO_IDX_W  = 5;
    localparam int unsigned PIX_ADDR_W = 16;
    localparam int unsigned PIX_VAL_W  = 8;
    localparam int unsigned RF_PORTS  = 4;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 80;

    // register numbers with fixed meaning
    localparam logic [REG_IDX_W-1:0] REG_ZERO  = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMM1  = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMM2  = 4'd2;
    localparam logic [REG_IDX_W-1:0] FIRST_GPR = 4'd3;

    // I/O register map
    localparam int unsigned IO_IRQ0_EN   = 0;
    localparam int unsigned IO_IRQ1_EN   = 1;
    localparam int unsigned IO_IRQ2_EN   = 2;
    localparam int unsigned IO_IRQ0_ST   = 3;
    localparam int unsigned IO_IRQ1_ST   = 4;
    localparam int unsigned IO_IRQ2_ST   = 5;
    localparam int unsigned IO_IRQ_HANDLER = 6;
    localparam int unsigned IO_IRQ_RETURN  = 7;
    localparam int unsigned IO_CLKS      = 8;
    localparam int unsigned IO_MON_ADDR  = 20;
    localparam int unsigned IO_MON_DATA  = 21;
    localparam int unsigned IO_MON_CMD   = 22;

    typedef enum logic [7:0] {
        OP_ADD  = 8'd0,  OP_SUB = 8'd1,  OP_MAC = 8'd2,  OP_AND = 8'd3,
        OP_OR   = 8'd4,  OP_XOR = 8'd5,  OP_SLL = 8'd6,  OP_SRA = 8'd7,
        OP_SRL  = 8'd8,  OP_BEQ = 8'd9,  OP_BNE = 8'd10, OP_BLT = 8'd11,
        OP_BGT  = 8'd12, OP_BLE = 8'd13, OP_BGE = 8'd14, OP_JAL = 8'd15,
        OP_LW   = 8'd16, OP_SW  = 8'd17, OP_RETI = 8'd18, OP_IN = 8'd19,
        OP_OUT  = 8'd20, OP_HALT = 8'd21
    } opcode_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [IRQ_W-1:0]     irq_pending_in;
        logic [IMM_W-1:0]     immediate_two;
        logic [IMM_W-1:0]     immediate_one;
        logic [REG_IDX_W-1:0] src_c_reg;
        logic [REG_IDX_W-1:0] src_b_reg;
        logic [REG_IDX_W-1:0] src_a_reg;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [7:0]           opcode;
    } in_item_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [PIX_VAL_W-1:0]  pixel_value;
        logic [PIX_ADDR_W-1:0] pixel_addr;
        logic                  pixel_write;
        logic [XLEN-1:0]       io_value;
        logic [IO_IDX_W-1:0]   io_index;
        logic                  io_write;
        logic                  interrupt_taken;
        logic                  halted;
        logic [PC_W-1:0]       next_pc;
    } out_item_t;

    function automatic logic [XLEN-1:0] sext_imm(input logic [IMM_W-1:0] imm);
        sext_imm = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
    endfunction

endpackage

>>> rtl/core/sce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; a read that collides with a write returns the old word.
module sce_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/simple_cpu_execute_with_interrupts_core.sv
// Top level of the instruction execute core with masked interrupts.
// Depends on sce_pkg and sce_ram (register file copies and data memory).
//
//  channel | dir | payload                                   | transfer when
//  s_      | in  | one decoded instruction + irq pending bits | s_tvalid & s_tready
//  m_      | out | next pc, status, I/O and pixel report      | m_tvalid & m_tready
//
// One instruction per cycle unless a load stall or a stalled output holds it. A load
// followed directly by an instruction that names the load's destination register
// stalls until the memory read is done. After reset, a clearing pass zeroes the
// DATA_WORDS data memory words while s_tready stays low.
// A stalled result holds in the output register; one more instruction may
// wait in the execute stage behind it.
module simple_cpu_execute_with_interrupts_core #(
    parameter int unsigned DATA_WORDS   = sce_pkg::DATA_WORDS,
    parameter int unsigned IO_REG_COUNT = sce_pkg::IO_REG_COUNT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata, from bit 0: opcode, dest_reg, src_a_reg, src_b_reg, src_c_reg,
    //   immediate_one, immediate_two, irq_pending_in, zero fill
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sce_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata, from bit 0: next_pc, halted, interrupt_taken, io_write, io_index,
    //   io_value, pixel_write, pixel_addr, pixel_value, zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sce_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned DADDR_W = $clog2(DATA_WORDS);
    localparam int unsigned XLEN    = sce_pkg::XLEN;
    localparam int unsigned RIW     = sce_pkg::REG_IDX_W;
    localparam int unsigned PC_W    = sce_pkg::PC_W;
    localparam int unsigned NPORT   = sce_pkg::RF_PORTS;

    // ---------------- control and state registers ----------------
    logic                   clear_busy_reg;
    logic [DADDR_W-1:0]     clear_addr_reg;

    logic                   e_valid_reg;
    sce_pkg::in_item_t      e_item_reg;

    logic                   m_wen_reg;
    logic                   m_is_load_reg;
    logic [RIW-1:0]         m_rd_reg;
    logic [XLEN-1:0]        m_data_reg;

    logic                   w_wen_reg;
    logic [RIW-1:0]         w_rd_reg;
    logic [XLEN-1:0]        w_data_reg;

    logic [sce_pkg::REG_COUNT-1:0] rf_valid_reg;

    logic                   out_valid_reg;
    sce_pkg::out_item_t     out_item_reg;

    logic [PC_W-1:0]        pc_reg;
    logic                   in_irq_reg;
    logic                   halted_reg;
    logic [XLEN-1:0]        io_reg [IO_REG_COUNT];

    // ---------------- handshake and hazard ----------------
    sce_pkg::in_item_t      in_item;
    logic                   out_free;
    logic                   load_hazard;
    logic                   e_fire;
    logic                   hold_e;

    assign in_item  = sce_pkg::in_item_t'(s_tdata[$bits(sce_pkg::in_item_t)-1:0]);
    assign out_free = !out_valid_reg || m_tready;

    // a load still in flight cannot forward: wait for its write
    assign load_hazard = e_valid_reg && m_wen_reg && m_is_load_reg &&
                         (e_item_reg.src_a_reg == m_rd_reg ||
                          e_item_reg.src_b_reg == m_rd_reg ||
                          e_item_reg.src_c_reg == m_rd_reg ||
                          e_item_reg.dest_reg  == m_rd_reg);

    assign e_fire   = e_valid_reg && !load_hazard && out_free;
    assign hold_e   = e_valid_reg && !e_fire;
    assign s_tready = !clear_busy_reg && (!e_valid_reg || e_fire);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sce_pkg::M_TDATA_W - $bits(sce_pkg::out_item_t)){1'b0}},
                       out_item_reg};

    // ---------------- register file: one copy per read port ----------------
    logic [RIW-1:0]  src_idx [NPORT];
    logic [RIW-1:0]  rf_raddr [NPORT];
    logic [XLEN-1:0] rf_rdata [NPORT];
    logic [XLEN-1:0] operand [NPORT];
    logic [XLEN-1:0] m_wdata;
    logic [XLEN-1:0] dm_rdata;

    assign src_idx[0] = e_item_reg.src_a_reg;
    assign src_idx[1] = e_item_reg.src_b_reg;
    assign src_idx[2] = e_item_reg.src_c_reg;
    assign src_idx[3] = e_item_reg.dest_reg;

    // re-read for a held instruction so only the latest write needs forwarding
    assign rf_raddr[0] = hold_e ? e_item_reg.src_a_reg : in_item.src_a_reg;
    assign rf_raddr[1] = hold_e ? e_item_reg.src_b_reg : in_item.src_b_reg;
    assign rf_raddr[2] = hold_e ? e_item_reg.src_c_reg : in_item.src_c_reg;
    assign rf_raddr[3] = hold_e ? e_item_reg.dest_reg  : in_item.dest_reg;

    assign m_wdata = m_is_load_reg ? dm_rdata + m_data_reg : m_data_reg;

    for (genvar p = 0; p < NPORT; p++) begin : g_rf
        sce_ram #(
            .WIDTH (XLEN),
            .DEPTH (sce_pkg::REG_COUNT)
        ) u_rf (
            .aclk    (aclk),
            .wr_en   (m_wen_reg),
            .wr_addr (m_rd_reg),
            .wr_data (m_wdata),
            .rd_addr (rf_raddr[p]),
            .rd_data (rf_rdata[p])
        );

        always_comb begin
            priority if (src_idx[p] == sce_pkg::REG_ZERO) begin
                operand[p] = '0;
            end else if (src_idx[p] == sce_pkg::REG_IMM1) begin
                operand[p] = sce_pkg::sext_imm(e_item_reg.immediate_one);
            end else if (src_idx[p] == sce_pkg::REG_IMM2) begin
                operand[p] = sce_pkg::sext_imm(e_item_reg.immediate_two);
            end else if (m_wen_reg && m_rd_reg == src_idx[p]) begin
                operand[p] = m_data_reg;
            end else if (w_wen_reg && w_rd_reg == src_idx[p]) begin
                operand[p] = w_data_reg;
            end else if (rf_valid_reg[src_idx[p]]) begin
                operand[p] = rf_rdata[p];
            end else begin
                operand[p] = '0;
            end
        end
    end

    // ---------------- execute ----------------
    logic [XLEN-1:0]        opa, opb, opc, opd;
    logic [XLEN-1:0]        sum_ab;
    logic [sce_pkg::SHAMT_W-1:0] shamt;
    logic                   rd_writable;
    logic                   rf_we;
    logic                   rf_is_load;
    logic [XLEN-1:0]        rf_data;
    logic                   dm_we;
    logic [XLEN-1:0]        dm_wdata;
    logic [XLEN-1:0]        io_nx [IO_REG_COUNT];
    logic [PC_W-1:0]        pc_nx;
    logic                   in_irq_nx;
    logic                   halt_now;
    logic                   irq_line;
    sce_pkg::out_item_t     res;

    assign opa    = operand[0];
    assign opb    = operand[1];
    assign opc    = operand[2];
    assign opd    = operand[3];
    assign sum_ab = opa + opb;
    assign shamt  = opb[sce_pkg::SHAMT_W-1:0];
    assign rd_writable = e_item_reg.dest_reg >= sce_pkg::FIRST_GPR;

    always_comb begin
        logic [XLEN-1:0] io_sel;
        logic [XLEN-1:0] prod;

        io_sel     = sum_ab;
        prod       = opa * opb;
        io_nx      = io_reg;
        pc_nx      = pc_reg + PC_W'(1);
        in_irq_nx  = in_irq_reg;
        halt_now   = 1'b0;
        rf_we      = 1'b0;
        rf_is_load = 1'b0;
        rf_data    = '0;
        dm_we      = 1'b0;
        dm_wdata   = opc + opd;
        res        = '0;
        irq_line   = 1'b0;

        if (e_item_reg.irq_pending_in[0]) io_nx[sce_pkg::IO_IRQ0_ST] = XLEN'(1);
        if (e_item_reg.irq_pending_in[1]) io_nx[sce_pkg::IO_IRQ1_ST] = XLEN'(1);
        if (e_item_reg.irq_pending_in[2]) io_nx[sce_pkg::IO_IRQ2_ST] = XLEN'(1);

        unique case (e_item_reg.opcode)
            sce_pkg::OP_ADD: begin rf_we = 1'b1; rf_data = opa + opb + opc; end
            sce_pkg::OP_SUB: begin rf_we = 1'b1; rf_data = opa - opb - opc; end
            sce_pkg::OP_MAC: begin rf_we = 1'b1; rf_data = prod + opc; end
            sce_pkg::OP_AND: begin rf_we = 1'b1; rf_data = opa & opb & opc; end
            sce_pkg::OP_OR:  begin rf_we = 1'b1; rf_data = opa | opb | opc; end
            sce_pkg::OP_XOR: begin rf_we = 1'b1; rf_data = opa ^ opb ^ opc; end
            sce_pkg::OP_SLL: begin rf_we = 1'b1; rf_data = opa << shamt; end
            sce_pkg::OP_SRA: begin
                rf_we = 1'b1;
                rf_data = XLEN'($signed(opa) >>> shamt);
            end
            sce_pkg::OP_SRL: begin rf_we = 1'b1; rf_data = opa >> shamt; end
            sce_pkg::OP_BEQ: if (opa == opb) pc_nx = opc[PC_W-1:0];
            sce_pkg::OP_BNE: if (opa != opb) pc_nx = opc[PC_W-1:0];
            sce_pkg::OP_BLT: if ($signed(opa) < $signed(opb)) pc_nx = opc[PC_W-1:0];
            sce_pkg::OP_BGT: if ($signed(opa) > $signed(opb)) pc_nx = opc[PC_W-1:0];
            sce_pkg::OP_BLE: if ($signed(opa) <= $signed(opb)) pc_nx = opc[PC_W-1:0];
            sce_pkg::OP_BGE: if ($signed(opa) >= $signed(opb)) pc_nx = opc[PC_W-1:0];
            sce_pkg::OP_JAL: begin
                rf_we   = 1'b1;
                rf_data = XLEN'(pc_nx);
                pc_nx   = opc[PC_W-1:0];
            end
            sce_pkg::OP_LW: begin
                // data word arrives next cycle; add rm there
                rf_we      = 1'b1;
                rf_is_load = 1'b1;
                rf_data    = opc;
            end
            sce_pkg::OP_SW: dm_we = 1'b1;
            sce_pkg::OP_RETI: begin
                pc_nx     = io_nx[sce_pkg::IO_IRQ_RETURN][PC_W-1:0];
                in_irq_nx = 1'b0;
            end
            sce_pkg::OP_IN: begin
                rf_we = 1'b1;
                if (io_sel == XLEN'(sce_pkg::IO_MON_CMD) ||
                    io_sel >= XLEN'(IO_REG_COUNT)) begin
                    rf_data = '0;
                end else begin
                    rf_data = io_nx[io_sel[sce_pkg::IO_IDX_W-1:0]];
                end
            end
            sce_pkg::OP_OUT: begin
                if (io_sel < XLEN'(IO_REG_COUNT)) begin
                    io_nx[io_sel[sce_pkg::IO_IDX_W-1:0]] = opc;
                    res.io_write = 1'b1;
                    res.io_index = io_sel[sce_pkg::IO_IDX_W-1:0];
                    res.io_value = opc;
                    if (io_nx[sce_pkg::IO_MON_CMD] == XLEN'(1)) begin
                        res.pixel_write = 1'b1;
                        res.pixel_addr  =
                            io_nx[sce_pkg::IO_MON_ADDR][sce_pkg::PIX_ADDR_W-1:0];
                        res.pixel_value =
                            io_nx[sce_pkg::IO_MON_DATA][sce_pkg::PIX_VAL_W-1:0];
                        io_nx[sce_pkg::IO_MON_CMD] = '0;
                    end
                end
            end
            default: begin
                halt_now = 1'b1;
                pc_nx    = pc_reg;
            end
        endcase

        if (!halt_now) begin
            irq_line = ((io_nx[sce_pkg::IO_IRQ0_EN] & io_nx[sce_pkg::IO_IRQ0_ST]) |
                        (io_nx[sce_pkg::IO_IRQ1_EN] & io_nx[sce_pkg::IO_IRQ1_ST]) |
                        (io_nx[sce_pkg::IO_IRQ2_EN] & io_nx[sce_pkg::IO_IRQ2_ST]))
                       == XLEN'(1);
            if (irq_line && !in_irq_nx) begin
                io_nx[sce_pkg::IO_IRQ_RETURN] = XLEN'(pc_nx);
                pc_nx     = io_nx[sce_pkg::IO_IRQ_HANDLER][PC_W-1:0];
                in_irq_nx = 1'b1;
                res.interrupt_taken = 1'b1;
            end
        end

        io_nx[sce_pkg::IO_CLKS] = io_nx[sce_pkg::IO_CLKS] + XLEN'(1);
        rf_we       = rf_we && rd_writable;
        res.next_pc = pc_nx;
        res.halted  = halt_now;

        // a halted core reports its pc and changes nothing
        if (halted_reg) begin
            res         = '0;
            res.next_pc = pc_reg;
            res.halted  = 1'b1;
            rf_we       = 1'b0;
            dm_we       = 1'b0;
        end
    end

    // ---------------- data memory ----------------
    logic                dmem_we;
    logic [DADDR_W-1:0]  dmem_waddr;
    logic [XLEN-1:0]     dmem_wdata;

    assign dmem_we    = clear_busy_reg || (e_fire && dm_we);
    assign dmem_waddr = clear_busy_reg ? clear_addr_reg : sum_ab[DADDR_W-1:0];
    assign dmem_wdata = clear_busy_reg ? '0 : dm_wdata;

    sce_ram #(
        .WIDTH (XLEN),
        .DEPTH (DATA_WORDS)
    ) u_dmem (
        .aclk    (aclk),
        .wr_en   (dmem_we),
        .wr_addr (dmem_waddr),
        .wr_data (dmem_wdata),
        .rd_addr (sum_ab[DADDR_W-1:0]),
        .rd_data (dm_rdata)
    );

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            e_valid_reg    <= 1'b0;
            m_wen_reg      <= 1'b0;
            w_wen_reg      <= 1'b0;
            rf_valid_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= '0;
            in_irq_reg     <= 1'b0;
            halted_reg     <= 1'b0;
            for (int i = 0; i < int'(IO_REG_COUNT); i++) begin
                io_reg[i] <= '0;
            end
        end else begin
            if (clear_busy_reg) begin
                clear_addr_reg <= clear_addr_reg + DADDR_W'(1);
                if (clear_addr_reg == DADDR_W'(DATA_WORDS - 1)) begin
                    clear_busy_reg <= 1'b0;
                end
            end

            if (s_tvalid && s_tready) begin
                e_valid_reg <= 1'b1;
            end else if (e_fire) begin
                e_valid_reg <= 1'b0;
            end

            m_wen_reg <= e_fire && rf_we;
            w_wen_reg <= m_wen_reg;
            if (m_wen_reg) begin
                rf_valid_reg[m_rd_reg] <= 1'b1;
            end

            if (e_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (e_fire && !halted_reg) begin
                pc_reg     <= pc_nx;
                in_irq_reg <= in_irq_nx;
                halted_reg <= halt_now;
                io_reg     <= io_nx;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            e_item_reg <= in_item;
        end
        m_is_load_reg <= rf_is_load;
        m_rd_reg      <= e_item_reg.dest_reg;
        m_data_reg    <= rf_data;
        w_rd_reg      <= m_rd_reg;
        w_data_reg    <= m_wdata;
        if (e_fire) begin
            out_item_reg <= res;
        end
    end

endmodule

>>> rtl/core/sce_checker.sv
// Port-level checker for the execute core, bound to its top level.
// Depends on sce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sce_port_checks (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sce_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sce_pkg::M_TDATA_W-1:0] m_tdata
);

    // m_tdata bits: 12 halted, 13 interrupt_taken, 14 io_write,
    // 51:15 io_index and io_value, 52 pixel_write
    `SCE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `SCE_ASSERT_NOW(a_halt_quiet, m_tvalid && m_tdata[12], !m_tdata[13] && !m_tdata[14] && !m_tdata[52], "halt reported with side effects")
    `SCE_ASSERT_NOW(a_pixel_needs_io, m_tvalid && m_tdata[52], m_tdata[14], "pixel write without I/O write")
    `SCE_ASSERT_NOW(a_io_zero, m_tvalid && !m_tdata[14], m_tdata[51:15] == '0, "I/O fields set without I/O write")

endmodule

bind simple_cpu_execute_with_interrupts_core sce_port_checks u_sce_port_checks (.*);

>>> sim/sce_checker.sv
// Checker for the execute core: watches both stream channels, predicts each
// result from a private machine model and compares field by field. Uses sce_pkg.
module sce_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sce_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sce_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import sce_pkg::*;

    logic [31:0] gpr [REG_COUNT];
    logic [31:0] dmem [DATA_WORDS];
    logic [31:0] ioreg [IO_REG_COUNT];
    logic [PC_W-1:0] pc;
    logic in_isr;
    logic stopped;
    out_item_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic logic [31:0] reg_value(logic [3:0] i, logic [31:0] i1, logic [31:0] i2);
        if (i == REG_ZERO) return 0;
        if (i == REG_IMM1) return i1;
        if (i == REG_IMM2) return i2;
        return gpr[i];
    endfunction

    function automatic void reg_store(logic [3:0] i, logic [31:0] v);
        if (i >= FIRST_GPR) gpr[i] = v;
    endfunction

    function automatic out_item_t execute(in_item_t it);
        out_item_t r;
        logic [31:0] i1, i2, a, b, c, idx, irq;
        logic [PC_W-1:0] npc;
        logic [4:0] sh;
        logic halt_now;
        r = '0;
        if (stopped) begin
            r.next_pc = pc;
            r.halted = 1;
            return r;
        end
        for (int k = 0; k < 3; k++)
            if (it.irq_pending_in[k]) ioreg[IO_IRQ0_ST+k] = 1;
        i1 = {{20{it.immediate_one[11]}}, it.immediate_one};
        i2 = {{20{it.immediate_two[11]}}, it.immediate_two};
        a = reg_value(it.src_a_reg, i1, i2);
        b = reg_value(it.src_b_reg, i1, i2);
        c = reg_value(it.src_c_reg, i1, i2);
        sh = b[4:0];
        npc = pc + 1'b1;
        halt_now = 0;
        case (it.opcode)
            OP_ADD: reg_store(it.dest_reg, a + b + c);
            OP_SUB: reg_store(it.dest_reg, a - b - c);
            OP_MAC: reg_store(it.dest_reg, a * b + c);
            OP_AND: reg_store(it.dest_reg, a & b & c);
            OP_OR:  reg_store(it.dest_reg, a | b | c);
            OP_XOR: reg_store(it.dest_reg, a ^ b ^ c);
            OP_SLL: reg_store(it.dest_reg, a << sh);
            OP_SRA: reg_store(it.dest_reg, $signed(a) >>> sh);
            OP_SRL: reg_store(it.dest_reg, a >> sh);
            OP_BEQ: if (a == b) npc = c[11:0];
            OP_BNE: if (a != b) npc = c[11:0];
            OP_BLT: if ($signed(a) < $signed(b)) npc = c[11:0];
            OP_BGT: if ($signed(a) > $signed(b)) npc = c[11:0];
            OP_BLE: if ($signed(a) <= $signed(b)) npc = c[11:0];
            OP_BGE: if ($signed(a) >= $signed(b)) npc = c[11:0];
            OP_JAL: begin
                reg_store(it.dest_reg, 32'(npc));
                npc = c[11:0];
            end
            OP_LW: reg_store(it.dest_reg, dmem[(a + b) % DATA_WORDS] + c);
            OP_SW: dmem[(a + b) % DATA_WORDS] = c + reg_value(it.dest_reg, i1, i2);
            OP_RETI: begin
                npc = ioreg[IO_IRQ_RETURN][11:0];
                in_isr = 0;
            end
            OP_IN: begin
                idx = a + b;
                if (idx == IO_MON_CMD || idx >= IO_REG_COUNT) reg_store(it.dest_reg, 0);
                else reg_store(it.dest_reg, ioreg[idx]);
            end
            OP_OUT: begin
                idx = a + b;
                if (idx < IO_REG_COUNT) begin
                    ioreg[idx] = c;
                    r.io_write = 1;
                    r.io_index = idx[4:0];
                    r.io_value = c;
                    if (ioreg[IO_MON_CMD] == 1) begin
                        r.pixel_write = 1;
                        r.pixel_addr = ioreg[IO_MON_ADDR][15:0];
                        r.pixel_value = ioreg[IO_MON_DATA][7:0];
                        ioreg[IO_MON_CMD] = 0;
                    end
                end
            end
            default: begin
                halt_now = 1;
                npc = pc;
            end
        endcase
        if (halt_now) stopped = 1;
        else begin
            irq = (ioreg[IO_IRQ0_EN] & ioreg[IO_IRQ0_ST]) | (ioreg[IO_IRQ1_EN] & ioreg[IO_IRQ1_ST])
                | (ioreg[IO_IRQ2_EN] & ioreg[IO_IRQ2_ST]);
            if (irq == 1 && !in_isr) begin
                ioreg[IO_IRQ_RETURN] = 32'(npc);
                npc = ioreg[IO_IRQ_HANDLER][11:0];
                in_isr = 1;
                r.interrupt_taken = 1;
            end
        end
        ioreg[IO_CLKS] += 1;
        pc = npc;
        r.next_pc = npc;
        r.halted = halt_now;
        return r;
    endfunction

    initial begin
        foreach (gpr[i]) gpr[i] = 0;
        foreach (dmem[i]) dmem[i] = 0;
        foreach (ioreg[i]) ioreg[i] = 0;
        pc = 0;
        in_isr = 0;
        stopped = 0;
        fail_count = 0;
    end

    always @(posedge aclk) begin
        out_item_t got, want;
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(execute(in_item_t'(s_tdata[$bits(in_item_t)-1:0])));
        if (aresetn && m_tvalid && m_tready) begin
            got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[M_TDATA_W-1:$bits(out_item_t)] !== '0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: pc %h/%h halt %b/%b irq %b/%b io %b %h %h / %b %h %h pix %b %h %h / %b %h %h",
                            want.next_pc, got.next_pc, want.halted, got.halted,
                            want.interrupt_taken, got.interrupt_taken,
                            want.io_write, want.io_index, want.io_value,
                            got.io_write, got.io_index, got.io_value,
                            want.pixel_write, want.pixel_addr, want.pixel_value,
                            got.pixel_write, got.pixel_addr, got.pixel_value);
                end
            end
        end
    end
endmodule

>>> sim/simple_cpu_execute_with_interrupts_core_test.sv
// Top of the execute core test: drives instructions and back-pressure, and
// gives the verdict from sce_checker. Depends on sce_pkg and the core RTL.
module simple_cpu_execute_with_interrupts_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sce_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    int fail_count, pending_count;
    bit stim_done = 0;
    bit long_hold = 0;

    simple_cpu_execute_with_interrupts_core u_top (.*);
    sce_checker u_check (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // wrap-around and sign extremes for the random immediates
    function automatic logic [11:0] pick_imm();
        case ($urandom_range(0, 5))
            0: return 12'h800;
            1: return 12'h7FF;
            2: return 12'hFFF;
            3: return 12'($urandom_range(0, 24));
            default: return 12'($urandom);
        endcase
    endfunction

    // keep tvalid high between back-to-back items; drop it only for a gap
    task automatic send(in_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= S_TDATA_W'(it);
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic in_item_t make_op(opcode_t op, int rd, int rs, int rt, int rm,
                                         int i1, int i2, int irq);
        in_item_t it;
        it.opcode = op;
        it.dest_reg = 4'(rd);
        it.src_a_reg = 4'(rs);
        it.src_b_reg = 4'(rt);
        it.src_c_reg = 4'(rm);
        it.immediate_one = 12'(i1);
        it.immediate_two = 12'(i2);
        it.irq_pending_in = 3'(irq);
        return it;
    endfunction

    function automatic in_item_t random_op();
        in_item_t it;
        it = in_item_t'($urandom);
        it.opcode = 8'($urandom_range(0, 20));
        it.immediate_one = pick_imm();
        it.immediate_two = pick_imm();
        it.irq_pending_in = ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'b0;
        // in/out use small indices so the I/O map is exercised
        if (it.opcode == OP_IN || it.opcode == OP_OUT) begin
            it.src_a_reg = REG_IMM1;
            it.src_b_reg = REG_ZERO;
            it.immediate_one = 12'($urandom_range(0, 25));
            if ($urandom_range(0, 9) == 0) it.immediate_one = 12'($urandom);
        end
        return it;
    endfunction

    // receiver side: random stalls plus one long hold-off
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
            if (stim_done) gap = 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    initial begin
        int wait_cycles;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        // directed: program interrupts, pixel path, every opcode up to OP_OUT, extremes
        send(make_op(OP_ADD, 3, 1, 2, 0, 2047, -2048, 0));
        send(make_op(OP_OUT, 0, 1, 0, 2, 6, 100, 0));       // handler address
        send(make_op(OP_OUT, 0, 1, 0, 2, 20, -1, 0));       // monitor address
        send(make_op(OP_OUT, 0, 1, 0, 2, 21, 511, 0));      // monitor data
        send(make_op(OP_OUT, 0, 1, 0, 2, 22, 1, 0));        // monitor command, triggers pixel
        send(make_op(OP_OUT, 0, 1, 0, 2, 9, 7, 0));         // plain I/O write
        send(make_op(OP_IN, 4, 1, 0, 0, 22, 0, 0));
        send(make_op(OP_IN, 4, 1, 0, 0, 8, 0, 0));
        send(make_op(OP_OUT, 0, 1, 0, 2, 23, 5, 0));        // out of range
        send(make_op(OP_OUT, 0, 1, 0, 2, 0, 1, 0));         // enable irq0
        send(make_op(OP_SUB, 5, 1, 2, 3, -2048, 2047, 1));  // takes irq
        send(make_op(OP_MAC, 6, 1, 2, 5, -2048, -2048, 7)); // nested blocked
        send(make_op(OP_RETI, 0, 0, 0, 0, 0, 0, 0));
        send(make_op(OP_OUT, 0, 1, 0, 0, 0, 0, 0));
        send(make_op(OP_SLL, 7, 1, 2, 0, -1, 63, 0));
        send(make_op(OP_SRA, 7, 1, 2, 0, -2048, 31, 0));
        send(make_op(OP_SRL, 7, 1, 2, 0, -2048, 33, 0));
        send(make_op(OP_AND, 8, 1, 2, 3, -1, 255, 0));
        send(make_op(OP_OR, 8, 1, 2, 3, 4, 8, 0));
        send(make_op(OP_XOR, 8, 1, 2, 3, 4, 8, 0));
        send(make_op(OP_SW, 3, 1, 2, 1, -1, 0, 0));         // address wraps
        send(make_op(OP_LW, 9, 1, 2, 0, -1, 0, 0));
        send(make_op(OP_ADD, 10, 9, 9, 0, 0, 0, 0));        // load-use
        send(make_op(OP_JAL, 11, 0, 0, 1, 0, 0, 0));
        for (int op = OP_BEQ; op <= OP_BGE; op++)
            send(make_op(opcode_t'(op), 0, 1, 2, 1, -5, 3, 0));
        for (int n = 0; n < 1300; n++) begin
            if (n == 400) long_hold = 1;
            send(random_op());
        end
        send(make_op(opcode_t'(8'hFF), 0, 0, 0, 0, 0, 0, 0)); // unknown halts
        send(make_op(OP_ADD, 3, 1, 1, 1, 1, 1, 0));           // ignored after halt
        s_tvalid <= 0;
        stim_done = 1;
        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
